// File: design/wad_pkg.sv
// shared types and constants for the windowed average and deviation unit
package wad_pkg;

    // default geometry
    localparam int DEFAULT_DEPTH    = 1024;
    localparam int DEFAULT_SAMPLE_W = 24;

    // fixed widths of the running sums and of the configuration registers
    localparam int SUM_W     = 35;
    localparam int SQ_W      = 60;
    localparam int DEC_W     = 16;
    localparam int WIN_W     = 10;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    // largest value of the squared deviation sum
    localparam logic [SQ_W-1:0] SQ_MAX = {1'b0, {(SQ_W-1){1'b1}}};

    // reset value of the short window length
    localparam logic [WIN_W-1:0] WIN_RESET = 10'd128;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WINDOW = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_OLD,
        ST_RD_CUR,
        ST_SUMS,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_DEV_GO,
        ST_DEV_WAIT,
        ST_ROOT_WAIT,
        ST_FIN
    } state_t;

    // phase of the window fill for the sample being worked on
    typedef enum logic [1:0] {
        CASE_FILL_SHORT,
        CASE_FILL_LONG,
        CASE_FULL
    } case_t;

endpackage

// File: design/windowed_average_and_deviation_unit.sv
// top level: sample rings, window sums and sequencer of the serial units
//
// channel  | dir | beat contents (lowest bits first)
// s_       | in  | tdata: power_sample
// m_       | out | tdata: short_average, long_average, deviation; tuser: long_window_full
// cfg_     | in  | index 0 decimation_length, index 1 short_window
//
// a skipped tick gives no beat
// a used sample runs the 35-step mean dividers and the squarer; after the
// short-window fill it also runs the 60-step divider of the squared sum and the
// 30-step square root
// one sample is worked on at a time; the next is taken while the result waits
// synchronous active-low reset; ring contents need no clearing
module windowed_average_and_deviation_unit #(
    parameter int BUFFER_DEPTH = wad_pkg::DEFAULT_DEPTH,
    parameter int SAMPLE_WIDTH = wad_pkg::DEFAULT_SAMPLE_W
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]         s_tdata,   // power_sample
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // short_average, long_average, deviation
    output logic [((3*SAMPLE_WIDTH-1+7)/8)*8-1:0]     m_tdata,
    output logic                                      m_tuser,   // long_window_full
    input  logic                                      cfg_we,
    input  logic [wad_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  logic [wad_pkg::CFG_W-1:0]                 cfg_wdata
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int AW     = $clog2(BUFFER_DEPTH);
    localparam int CW     = $clog2(BUFFER_DEPTH + 2);
    localparam int CMP_W  = (CW > wad_pkg::WIN_W) ? CW : wad_pkg::WIN_W;
    localparam int DW     = SW + 1;
    localparam int PW     = 2 * DW;
    localparam int ACC_W  = ((PW > wad_pkg::SQ_W) ? PW : wad_pkg::SQ_W) + 2;
    localparam int DEV_W  = SW - 1;
    localparam int RT_W   = wad_pkg::SQ_W / 2;
    localparam int RC_W   = ((RT_W > DEV_W) ? RT_W : DEV_W) + 1;
    localparam int SUM_W  = wad_pkg::SUM_W;
    localparam int SQ_W   = wad_pkg::SQ_W;
    localparam int M_TD_W = ((3*SAMPLE_WIDTH-1+7)/8)*8;

    // sample and mean rings
    logic signed [SW-1:0] sample_ring [BUFFER_DEPTH];
    logic signed [SW-1:0] mean_ring   [BUFFER_DEPTH];

    wad_pkg::state_t state_reg, state_next;
    wad_pkg::case_t  case_reg;

    logic [wad_pkg::DEC_W-1:0] dec_reg;
    logic [wad_pkg::WIN_W-1:0] win_reg;
    logic [wad_pkg::DEC_W-1:0] tick_reg;
    logic [AW-1:0]             wp_reg;
    logic [CW-1:0]             fill_reg;
    logic [CW-1:0]             w_reg;
    logic signed [SW-1:0]      x_reg;
    logic signed [SW-1:0]      old_s_reg;
    logic signed [SW-1:0]      s_q_reg;
    logic signed [SW-1:0]      m_q_reg;
    logic signed [SUM_W-1:0]   short_sum_reg;
    logic signed [SUM_W-1:0]   long_sum_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic [PW-1:0]             od_sq_reg;
    logic [DEV_W-1:0]          held_dev_reg;
    logic signed [SW-1:0]      short_avg_reg;
    logic signed [SW-1:0]      long_avg_reg;
    logic                      m_tvalid_reg;
    logic [M_TD_W-1:0]         m_tdata_reg;
    logic                      m_tuser_reg;

    logic [CMP_W-1:0] win_ext;
    logic [CW-1:0]    w_eff;
    logic [CW:0]      idx_wide;
    logic [AW-1:0]    idx;
    logic [AW-1:0]    rd_addr;
    logic             accept;
    logic             out_free;
    logic             wr_en;

    logic [SUM_W-1:0] short_mag, long_mag;
    logic [CW-1:0]    short_dvs, long_dvs;
    logic             div_go, dev_go, mul_go, root_go;
    logic             sdiv_done, ldiv_done, ddiv_done, mul_done, root_done;
    logic [SUM_W-1:0] short_quo, long_quo;
    logic [SQ_W-1:0]  dev_quo;
    logic [PW-1:0]    mul_prod;
    logic [RT_W-1:0]  root_val;

    logic signed [DW-1:0] od_diff, d_diff;
    logic [DW-1:0]        mul_op;

    logic signed [ACC_W-1:0] acc_a, acc_q, acc_lim, acc_s;
    logic [SQ_W-1:0]         sq_new;

    // saturate a truncated quotient with its sign to the sample range
    function automatic logic [SW-1:0] sat_mean(input logic neg, input logic [SUM_W-1:0] q);
        logic [SUM_W-1:0] lim_pos;
        logic [SUM_W-1:0] lim_neg;
        logic [SUM_W-1:0] negq;
        lim_pos = SUM_W'({1'b0, {(SW-1){1'b1}}});
        lim_neg = SUM_W'({1'b1, {(SW-1){1'b0}}});
        negq    = -q;
        if (!neg) begin
            sat_mean = (q > lim_pos) ? {1'b0, {(SW-1){1'b1}}} : q[SW-1:0];
        end else begin
            sat_mean = (q > lim_neg) ? {1'b1, {(SW-1){1'b0}}} : negq[SW-1:0];
        end
    endfunction

    // effective short window and ring index of the sample leaving it
    always_comb begin
        win_ext = CMP_W'(win_reg);
        if (win_ext == '0) begin
            w_eff = CW'(1);
        end else if (win_ext >= CMP_W'(BUFFER_DEPTH)) begin
            w_eff = CW'(BUFFER_DEPTH - 1);
        end else begin
            w_eff = CW'(win_ext);
        end
        idx_wide = (CW+1)'(wp_reg) + (CW+1)'(BUFFER_DEPTH) - (CW+1)'(w_reg);
        if (idx_wide >= (CW+1)'(BUFFER_DEPTH)) begin
            idx_wide = idx_wide - (CW+1)'(BUFFER_DEPTH);
        end
        idx     = AW'(idx_wide);
        rd_addr = (state_reg == wad_pkg::ST_RD_OLD) ? idx : wp_reg;
    end

    // ring memories: one read port and one write port each
    always_ff @(posedge aclk) begin
        s_q_reg <= sample_ring[rd_addr];
        m_q_reg <= mean_ring[rd_addr];
        if (wr_en) begin
            sample_ring[wp_reg] <= x_reg;
            mean_ring[wp_reg]   <= long_avg_reg;
        end
    end

    // handshakes
    assign accept   = s_tvalid && (state_reg == wad_pkg::ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign wr_en    = (state_reg == wad_pkg::ST_FIN) && out_free;

    // operands of the serial units
    always_comb begin
        short_mag = short_sum_reg[SUM_W-1] ? SUM_W'(-short_sum_reg) : SUM_W'(short_sum_reg);
        long_mag  = long_sum_reg[SUM_W-1]  ? SUM_W'(-long_sum_reg)  : SUM_W'(long_sum_reg);
        short_dvs = (case_reg == wad_pkg::CASE_FILL_SHORT) ? fill_reg : w_reg;
        long_dvs  = (case_reg == wad_pkg::CASE_FULL) ? CW'(BUFFER_DEPTH) : fill_reg;
        od_diff   = DW'(s_q_reg) - DW'(m_q_reg);
        d_diff    = DW'(x_reg) - DW'(long_avg_reg);
        if (state_reg == wad_pkg::ST_SUMS) begin
            mul_op = od_diff[DW-1] ? DW'(-od_diff) : DW'(od_diff);
        end else begin
            mul_op = d_diff[DW-1] ? DW'(-d_diff) : DW'(d_diff);
        end
    end

    // squared sum update: drop the leaving square once the ring is full, add the new one, clamp
    always_comb begin
        acc_a = ACC_W'(sq_reg);
        if (case_reg == wad_pkg::CASE_FULL) begin
            acc_a = acc_a - ACC_W'(od_sq_reg);
        end
        acc_q   = ACC_W'(mul_prod);
        acc_lim = ACC_W'(wad_pkg::SQ_MAX) - acc_q;
        if (acc_a > acc_lim) begin
            acc_s = ACC_W'(wad_pkg::SQ_MAX);
        end else begin
            acc_s = acc_a + acc_q;
        end
        sq_new = acc_s[ACC_W-1] ? '0 : SQ_W'(acc_s);
    end

    // sequencer: next state and unit starts
    always_comb begin
        state_next = state_reg;
        div_go     = 1'b0;
        dev_go     = 1'b0;
        mul_go     = 1'b0;
        root_go    = 1'b0;
        case (state_reg)
            wad_pkg::ST_IDLE: begin
                if (accept && !(tick_reg < dec_reg)) begin
                    state_next = wad_pkg::ST_RD_OLD;
                end
            end
            wad_pkg::ST_RD_OLD:  state_next = wad_pkg::ST_RD_CUR;
            wad_pkg::ST_RD_CUR:  state_next = wad_pkg::ST_SUMS;
            wad_pkg::ST_SUMS: begin
                mul_go     = 1'b1;
                state_next = wad_pkg::ST_DIV_GO;
            end
            wad_pkg::ST_DIV_GO: begin
                div_go     = 1'b1;
                state_next = wad_pkg::ST_DIV_WAIT;
            end
            wad_pkg::ST_DIV_WAIT: begin
                if (sdiv_done) begin
                    state_next = wad_pkg::ST_MUL_GO;
                end
            end
            wad_pkg::ST_MUL_GO: begin
                mul_go     = 1'b1;
                state_next = wad_pkg::ST_MUL_WAIT;
            end
            wad_pkg::ST_MUL_WAIT: begin
                if (mul_done) begin
                    if (case_reg == wad_pkg::CASE_FILL_SHORT) begin
                        state_next = wad_pkg::ST_FIN;
                    end else begin
                        state_next = wad_pkg::ST_DEV_GO;
                    end
                end
            end
            wad_pkg::ST_DEV_GO: begin
                dev_go     = 1'b1;
                state_next = wad_pkg::ST_DEV_WAIT;
            end
            wad_pkg::ST_DEV_WAIT: begin
                if (ddiv_done) begin
                    root_go    = 1'b1;
                    state_next = wad_pkg::ST_ROOT_WAIT;
                end
            end
            wad_pkg::ST_ROOT_WAIT: begin
                if (root_done) begin
                    state_next = wad_pkg::ST_FIN;
                end
            end
            wad_pkg::ST_FIN: begin
                if (out_free) begin
                    state_next = wad_pkg::ST_IDLE;
                end
            end
            default: state_next = wad_pkg::ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wad_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_reg <= '0;
            win_reg <= wad_pkg::WIN_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                wad_pkg::CFG_DECIMATION:   dec_reg <= cfg_wdata;
                wad_pkg::CFG_SHORT_WINDOW: win_reg <= cfg_wdata[wad_pkg::WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // window state and running sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg      <= '0;
            wp_reg        <= '0;
            fill_reg      <= CW'(1);
            short_sum_reg <= '0;
            long_sum_reg  <= '0;
            sq_reg        <= '0;
            held_dev_reg  <= '0;
            case_reg      <= wad_pkg::CASE_FILL_SHORT;
        end else begin
            // decimation and capture of a used sample
            if (accept) begin
                if (tick_reg < dec_reg) begin
                    tick_reg <= tick_reg + 1'b1;
                end else begin
                    tick_reg <= '0;
                    w_reg    <= w_eff;
                    if (fill_reg <= w_eff) begin
                        case_reg <= wad_pkg::CASE_FILL_SHORT;
                    end else if (fill_reg <= CW'(BUFFER_DEPTH)) begin
                        case_reg <= wad_pkg::CASE_FILL_LONG;
                    end else begin
                        case_reg <= wad_pkg::CASE_FULL;
                    end
                end
            end
            // sums; the ring read now shows the sample at the write pointer
            if (state_reg == wad_pkg::ST_SUMS) begin
                case (case_reg)
                    wad_pkg::CASE_FILL_SHORT: begin
                        short_sum_reg <= short_sum_reg + SUM_W'(x_reg);
                        long_sum_reg  <= short_sum_reg + SUM_W'(x_reg);
                    end
                    wad_pkg::CASE_FILL_LONG: begin
                        short_sum_reg <= short_sum_reg + SUM_W'(x_reg) - SUM_W'(old_s_reg);
                        long_sum_reg  <= long_sum_reg + SUM_W'(x_reg);
                    end
                    default: begin
                        short_sum_reg <= short_sum_reg + SUM_W'(x_reg) - SUM_W'(old_s_reg);
                        long_sum_reg  <= long_sum_reg + SUM_W'(x_reg) - SUM_W'(s_q_reg);
                    end
                endcase
            end
            if ((state_reg == wad_pkg::ST_MUL_WAIT) && mul_done) begin
                sq_reg <= sq_new;
            end
            // saturated root of the mean square
            if ((state_reg == wad_pkg::ST_ROOT_WAIT) && root_done) begin
                if (RC_W'(root_val) > RC_W'({DEV_W{1'b1}})) begin
                    held_dev_reg <= {DEV_W{1'b1}};
                end else begin
                    held_dev_reg <= DEV_W'(root_val);
                end
            end
            if (wr_en) begin
                wp_reg <= (wp_reg == AW'(BUFFER_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                if (case_reg != wad_pkg::CASE_FULL) begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
        end
    end

    // payload captures
    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg <= s_tdata[SW-1:0];
        end
        if (state_reg == wad_pkg::ST_RD_CUR) begin
            old_s_reg <= s_q_reg;
        end
        if ((state_reg == wad_pkg::ST_DIV_WAIT) && sdiv_done) begin
            short_avg_reg <= sat_mean(short_sum_reg[SUM_W-1], short_quo);
            long_avg_reg  <= sat_mean(long_sum_reg[SUM_W-1], long_quo);
            od_sq_reg     <= mul_prod;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (wr_en) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            m_tdata_reg <= M_TD_W'({held_dev_reg, long_avg_reg, short_avg_reg});
            m_tuser_reg <= (case_reg == wad_pkg::CASE_FULL) ||
                           (fill_reg >= CW'(BUFFER_DEPTH));
        end
    end

    assign s_tready = (state_reg == wad_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // short-window mean divider
    wad_div #(.N(SUM_W), .M(CW)) u_short_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_go),
        .dividend (short_mag),
        .divisor  (short_dvs),
        .done     (sdiv_done),
        .quotient (short_quo)
    );

    // long-window mean divider
    wad_div #(.N(SUM_W), .M(CW)) u_long_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_go),
        .dividend (long_mag),
        .divisor  (long_dvs),
        .done     (ldiv_done),
        .quotient (long_quo)
    );

    // mean square divider
    wad_div #(.N(SQ_W), .M(CW)) u_dev_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (dev_go),
        .dividend (sq_reg),
        .divisor  (long_dvs),
        .done     (ddiv_done),
        .quotient (dev_quo)
    );

    // squarer for the leaving and the new deviation
    wad_square #(.W(DW)) u_square (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_go),
        .operand (mul_op),
        .done    (mul_done),
        .product (mul_prod)
    );

    // square root of the mean square
    wad_sqrt #(.N(SQ_W)) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_go),
        .radicand (dev_quo),
        .done     (root_done),
        .root     (root_val)
    );

    // both mean dividers run in lockstep
    a_div_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        sdiv_done == ldiv_done)
        else $error("mean dividers out of step");

    // a pending beat is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wad_pkg::ST_FIN) && m_tvalid_reg && !m_tready
        |=> state_reg == wad_pkg::ST_FIN)
        else $error("result beat overwritten");

    // once full the fill count stays put
    a_fill_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg == CW'(BUFFER_DEPTH + 1) |=> fill_reg == CW'(BUFFER_DEPTH + 1))
        else $error("fill count left full");

    // squared sum stays within its saturation limit after an update
    a_sq_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wad_pkg::ST_MUL_WAIT) && mul_done |=> !sq_reg[SQ_W-1])
        else $error("squared sum out of range");

endmodule

// File: design/wad_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module wad_div #(
    parameter int N = wad_pkg::SUM_W,
    parameter int M = 11
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [M-1:0] divisor,
    output logic         done,
    output logic [N-1:0] quotient
);

    localparam int CNT_W = $clog2(N + 1);

    logic [M:0]       rem_reg;
    logic [N-1:0]     quo_reg;
    logic [M-1:0]     dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [M:0] shifted;
    logic [M:0] diff;
    logic       ge;

    // trial subtraction of the divisor from the partial remainder
    always_comb begin
        shifted = {rem_reg[M-1:0], quo_reg[N-1]};
        ge      = shifted >= {1'b0, dvs_reg};
        diff    = shifted - {1'b0, dvs_reg};
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(N - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend bits leave at the top, quotient bits enter at the bottom
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff : shifted;
            quo_reg <= {quo_reg[N-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: design/wad_square.sv
// bit-serial squarer, one shift-add step per cycle
module wad_square #(
    parameter int W = wad_pkg::DEFAULT_SAMPLE_W + 1
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [W-1:0]   operand,
    output logic           done,
    output logic [2*W-1:0] product
);

    localparam int CNT_W = $clog2(W + 1);

    logic [2*W-1:0]   acc_reg;
    logic [2*W-1:0]   mcand_reg;
    logic [W-1:0]     mplier_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // add the shifted operand for each set multiplier bit
    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg    <= '0;
            mcand_reg  <= (2*W)'(operand);
            mplier_reg <= operand;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[2*W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// File: design/wad_sqrt.sv
// digit-by-digit integer square root, one root bit per cycle
module wad_sqrt #(
    parameter int N = wad_pkg::SQ_W
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [N-1:0]   radicand,
    output logic           done,
    output logic [N/2-1:0] root
);

    localparam int R     = N / 2;
    localparam int CNT_W = $clog2(R + 1);

    logic [N-1:0]     rad_reg;
    logic [R+1:0]     rem_reg;
    logic [R-1:0]     root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [R+2:0] rem_s;
    logic [R+2:0] trial;
    logic [R+2:0] diff;
    logic         ge;

    // bring down two radicand bits and try root*4+1
    always_comb begin
        rem_s = {rem_reg[R:0], rad_reg[N-1:N-2]};
        trial = (R+3)'({root_reg, 2'b01});
        ge    = rem_s >= trial;
        diff  = rem_s - trial;
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(R - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= ge ? diff[R+1:0] : rem_s[R+1:0];
            root_reg <= {root_reg[R-2:0], ge};
            rad_reg  <= {rad_reg[N-3:0], 2'b00};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: verif/wad_checker.sv
// checker for the windowed average and deviation unit: predicts each result and compares
module wad_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic        m_tuser,
    input  logic        cfg_we,
    input  logic [wad_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wad_pkg::CFG_W-1:0]     cfg_wdata,
    output int          errors,
    output int          pending
);

    localparam int RING = 1024;
    localparam longint SAMPLE_HI = 64'sd8388607;
    localparam longint SAMPLE_LO = -64'sd8388608;
    localparam longint SQ_TOP = 64'sh07FF_FFFF_FFFF_FFFF;
    localparam longint DEV_TOP = 64'sd8388607;

    typedef struct {
        logic [23:0] short_avg;
        logic [23:0] long_avg;
        logic [22:0] dev;
        logic        full;
    } stats_t;

    stats_t stats_q[$];

    // predictor state
    longint sample_hist [RING];
    longint mean_hist [RING];
    int     wr_pos;
    int     seen;
    int     skip_count;
    longint short_acc;
    longint long_acc;
    longint sq_acc;
    longint held_dev;
    int     dec_len;
    int     win_len;

    assign pending = stats_q.size();

    function automatic longint wrap35(input longint v);
        logic signed [34:0] t;
        t = v[34:0];
        return longint'(t);
    endfunction

    function automatic longint clamp24(input longint v);
        if (v > SAMPLE_HI) return SAMPLE_HI;
        if (v < SAMPLE_LO) return SAMPLE_LO;
        return v;
    endfunction

    function automatic longint add_square(input longint acc, input longint d);
        longint q;
        q = d * d;
        if (acc > SQ_TOP - q) return SQ_TOP;
        return acc + q;
    endfunction

    // bitwise integer square root, floor
    function automatic longint root_of(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // both operands are positive here, so the signed quotient is the unsigned one
    function automatic longint dev_over(input longint s, input int cnt);
        longint r;
        if (s <= 0 || cnt == 0) return 0;
        r = root_of(s / longint'(cnt));
        return (r > DEV_TOP) ? DEV_TOP : r;
    endfunction

    // work out the result of one accepted sample beat
    task automatic take_sample(input logic [23:0] raw);
        longint x, s_avg, l_avg, od;
        int w, idx;
        stats_t e;
        if (skip_count < dec_len) begin
            skip_count++;
            return;
        end
        skip_count = 0;
        x = $signed(raw);
        w = (win_len < 1) ? 1 : win_len;
        if (w > RING - 1) w = RING - 1;
        if (seen <= w) begin
            short_acc = wrap35(short_acc + x);
            s_avg = clamp24(short_acc / longint'(seen));
            seen++;
            long_acc = short_acc;
            l_avg = s_avg;
            sq_acc = add_square(sq_acc, x - l_avg);
        end else begin
            idx = (wr_pos + RING - w) % RING;
            short_acc = wrap35(short_acc + x - sample_hist[idx]);
            s_avg = clamp24(short_acc / longint'(w));
            if (seen <= RING) begin
                long_acc = wrap35(long_acc + x);
                l_avg = clamp24(long_acc / longint'(seen));
                sq_acc = add_square(sq_acc, x - l_avg);
                if (sq_acc < 0) sq_acc = 0;
                held_dev = dev_over(sq_acc, seen);
                seen++;
            end else begin
                od = sample_hist[wr_pos] - mean_hist[wr_pos];
                long_acc = wrap35(long_acc + x - sample_hist[wr_pos]);
                l_avg = clamp24(long_acc / longint'(RING));
                sq_acc = sq_acc - od * od;
                sq_acc = add_square(sq_acc, x - l_avg);
                if (sq_acc < 0) sq_acc = 0;
                held_dev = dev_over(sq_acc, RING);
            end
        end
        if (sq_acc < 0) sq_acc = 0;
        sample_hist[wr_pos] = x;
        mean_hist[wr_pos] = l_avg;
        wr_pos = (wr_pos + 1) % RING;
        e.short_avg = s_avg[23:0];
        e.long_avg = l_avg[23:0];
        e.dev = held_dev[22:0];
        e.full = (seen > RING);
        stats_q.push_back(e);
    endtask

    // compare one result beat with the oldest prediction
    task automatic check_result();
        stats_t e;
        if (stats_q.size() == 0) begin
            $error("unexpected result beat: tdata %h", m_tdata);
            errors++;
            return;
        end
        e = stats_q.pop_front();
        if (m_tdata[23:0] !== e.short_avg) begin
            $error("short_average: expected %h, got %h", e.short_avg, m_tdata[23:0]);
            errors++;
        end
        if (m_tdata[47:24] !== e.long_avg) begin
            $error("long_average: expected %h, got %h", e.long_avg, m_tdata[47:24]);
            errors++;
        end
        if (m_tdata[70:48] !== e.dev) begin
            $error("deviation: expected %h, got %h", e.dev, m_tdata[70:48]);
            errors++;
        end
        if (m_tuser !== e.full) begin
            $error("long_window_full: expected %b, got %b", e.full, m_tuser);
            errors++;
        end
    endtask

    // watch both channels and the register port
    always @(posedge aclk) begin
        if (!aresetn) begin
            errors = 0;
            wr_pos = 0;
            seen = 1;
            skip_count = 0;
            short_acc = 0;
            long_acc = 0;
            sq_acc = 0;
            held_dev = 0;
            dec_len = 0;
            win_len = int'(wad_pkg::WIN_RESET);
        end else begin
            if (cfg_we) begin
                if (cfg_index == wad_pkg::CFG_DECIMATION) begin
                    dec_len = int'(cfg_wdata);
                end else if (cfg_index == wad_pkg::CFG_SHORT_WINDOW) begin
                    win_len = int'(cfg_wdata[wad_pkg::WIN_W-1:0]);
                end
            end
            if (s_tvalid && s_tready) take_sample(s_tdata);
            if (m_tvalid && m_tready) check_result();
        end
    end
endmodule

// File: verif/tb_windowed_average_and_deviation_unit.sv
// testbench top: stimulus, back-pressure and verdict for the windowed average unit
module tb_windowed_average_and_deviation_unit;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE = 250;
    localparam int LONG_HOLD = 600;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    logic [wad_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [wad_pkg::CFG_W-1:0]     cfg_wdata;
    int errors;
    int pending;
    int cycles;
    bit send_burst;
    bit recv_burst;
    bit hold_req;

    windowed_average_and_deviation_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    wad_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .errors(errors), .pending(pending)
    );

    // clock
    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // watchdog
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stalls, occasional long hold-off
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = recv_burst ? 0 : $urandom_range(0, 13);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_req = 1'b0;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // one sample beat with a random gap in front
    task automatic send_beat(input logic [23:0] v);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        do @(posedge aclk); while (!s_tready);
    endtask

    // wait until every result is in, then let any skipped tick drain
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [wad_pkg::CFG_IDX_W-1:0] idx, input int value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[wad_pkg::CFG_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // sample mix: extremes, small values near zero, full-range noise
    function automatic logic [23:0] pick_sample();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
        if (r < 3) return 24'($signed($urandom_range(0, 512)) - 256);
        return 24'($urandom);
    endfunction

    task automatic random_run(input int n);
        for (int i = 0; i < n; i++) begin
            if (i % 64 == 0) begin
                send_burst = ($urandom_range(0, 3) == 0);
                recv_burst = ($urandom_range(0, 3) == 0);
            end
            send_beat(pick_sample());
        end
    endtask

    initial begin
        logic [23:0] corner [12];
        corner = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF, 24'h000001,
                   24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h555555,
                   24'hAAAAAA, 24'h000100};
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_we <= 1'b0;
        cfg_index <= wad_pkg::CFG_DECIMATION;
        cfg_wdata <= '0;
        send_burst = 1'b0;
        recv_burst = 1'b0;
        hold_req = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes with the reset window
        foreach (corner[i]) send_beat(corner[i]);
        drain();

        // widest decimation, then lowered below the tick count
        write_reg(wad_pkg::CFG_DECIMATION, 65535);
        repeat (6) send_beat(pick_sample());
        drain();
        write_reg(wad_pkg::CFG_DECIMATION, 2);
        random_run(30);
        drain();

        // smallest window, given as zero
        write_reg(wad_pkg::CFG_DECIMATION, 0);
        write_reg(wad_pkg::CFG_SHORT_WINDOW, 0);
        random_run(20);
        drain();

        // widest window over most of the ring, with a long hold-off
        write_reg(wad_pkg::CFG_SHORT_WINDOW, 1023);
        random_run(380);
        hold_req = 1'b1;
        random_run(100);
        drain();
        random_run(380);
        drain();

        // window lowered after a wide one: means saturate
        write_reg(wad_pkg::CFG_SHORT_WINDOW, 1);
        random_run(40);
        drain();

        // short window: the long window fills and the ring wraps
        write_reg(wad_pkg::CFG_SHORT_WINDOW, 5);
        random_run(110);
        drain();

        // moderate decimation on a full ring
        write_reg(wad_pkg::CFG_DECIMATION, 1);
        random_run(30);
        drain();

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// File: sim.f
design/wad_pkg.sv
design/wad_div.sv
design/wad_square.sv
design/wad_sqrt.sv
design/windowed_average_and_deviation_unit.sv
verif/wad_checker.sv
verif/tb_windowed_average_and_deviation_unit.sv
